// ----- hdl/pahs_pkg.sv -----
// ----------------------------------------------------------------------------
// Per-peer heartbeat scheduler package
// Widths, register indexes, codes, the peer table entry and the FSM types.
// ----------------------------------------------------------------------------
`default_nettype none

package pahs_pkg;

  localparam int PEER_SLOTS = 256;
  localparam int PEER_AW    = $clog2(PEER_SLOTS);
  localparam int PEER_W     = 8;
  localparam int TIME_W     = 48;
  localparam int CNT_W      = 48;
  localparam int TOT_W      = CNT_W + 1;
  localparam int RATE_W     = 32;
  localparam int LINK_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_AW     = 3;
  localparam int SCALE_W    = 20;
  localparam int PROD_W     = TOT_W + SCALE_W;
  localparam int DCNT_W     = $clog2(RATE_W);

  // Packets per second scale: microseconds in one second
  localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(1000000);

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_OWN_LINK  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_FAST_INTV = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SLOW_INTV = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_RATE_WIN  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_HIGH_THR  = 3'd4;

  localparam logic [CFG_W-1:0] RST_FAST_INTV = 32'd100000;
  localparam logic [CFG_W-1:0] RST_SLOW_INTV = 32'd5000000;
  localparam logic [CFG_W-1:0] RST_RATE_WIN  = 32'd1000000;
  localparam logic [CFG_W-1:0] RST_HIGH_THR  = 32'd100;

  // Result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_SKIP     = 2'd1;
  localparam logic [1:0] STS_PATH_ERR = 2'd2;
  localparam logic [1:0] STS_PLAN_ERR = 2'd3;

  // Path, plan and mode codes
  localparam logic [1:0] PATH_PRESENT   = 2'd0;
  localparam logic [1:0] PATH_ABSENT    = 2'd1;
  localparam logic [1:0] PLAN_VALID     = 2'd0;
  localparam logic [1:0] PLAN_NONE      = 2'd1;
  localparam logic [1:0] MODE_SINGLE    = 2'd0;
  localparam logic [1:0] MODE_REDUNDANT = 2'd1;

  typedef struct packed {
    logic              tracked;
    logic              baseline;
    logic [TIME_W-1:0] window_start;
    logic [TOT_W-1:0]  last_total;
    logic [TIME_W-1:0] last_beat;
    logic [RATE_W-1:0] rate;
  } ent_t;

  typedef struct packed {
    logic [TOT_W-1:0]  delta;
    logic [TIME_W-1:0] elapsed;
  } div_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN
  } ctl_state_e;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_SAT,
    D_RUN
  } div_state_e;

endpackage

`default_nettype wire

// ----- hdl/per_peer_adaptive_heartbeat_scheduler.sv -----
// ----------------------------------------------------------------------------
// Per-peer adaptive heartbeat scheduler
// Polls one peer per command, tracks its path, measures its packet rate and
// flags a heartbeat when the fast or slow interval has passed.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  command   start_i / busy_o           peer_id_i .. secondary_link_i
//  result    out_valid_o (strobe)       out_peer_id_o .. status_o
//  config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  A poll holds busy_o through its evaluate and finish states and strobes its
//  result from a register loaded in the finish state. A closing rate window
//  adds a wait state for serial division (one quotient bit a cycle) that ends
//  early on a saturated quotient. The table entry is written back before busy_o
//  drops; reset clears per-entry valid bits, and an invalid entry reads as zero.
//  The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module per_peer_adaptive_heartbeat_scheduler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output      logic                        busy_o,
  input  wire logic [pahs_pkg::PEER_W-1:0] peer_id_i,
  input  wire logic [1:0]                  path_status_i,
  input  wire logic [pahs_pkg::CNT_W-1:0]  tx_count_i,
  input  wire logic [pahs_pkg::CNT_W-1:0]  rx_count_i,
  input  wire logic [pahs_pkg::TIME_W-1:0] now_time_us_i,
  input  wire logic [1:0]                  plan_status_i,
  input  wire logic [1:0]                  plan_mode_i,
  input  wire logic [pahs_pkg::LINK_W-1:0] primary_link_i,
  input  wire logic [pahs_pkg::LINK_W-1:0] secondary_link_i,
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [pahs_pkg::CFG_AW-1:0] cfg_index_i,
  input  wire logic [pahs_pkg::CFG_W-1:0]  cfg_data_i,
  output      logic                        out_valid_o,
  output      logic [pahs_pkg::PEER_W-1:0] out_peer_id_o,
  output      logic                        send_heartbeat_o,
  output      logic                        link_in_use_o,
  output      logic                        fast_selected_o,
  output      logic [pahs_pkg::RATE_W-1:0] peer_rate_o,
  output      logic                        peer_tracked_o,
  output      logic [1:0]                  status_o
);
  import pahs_pkg::*;

  ctl_state_e st_q, st_d;

  // configuration
  logic [CFG_W-1:0] own_q, fast_q, slow_q, win_q, thr_q;

  // latched command
  logic [PEER_W-1:0] peer_q;
  logic [1:0]        path_q, pst_q, mode_q;
  logic [TOT_W-1:0]  total_q;
  logic [TIME_W-1:0] now_q;
  logic [LINK_W-1:0] prim_q, sec_q;

  // peer table
  ent_t                  ent_mem [PEER_SLOTS];
  logic [PEER_SLOTS-1:0] vld_q;
  ent_t                  rd_q;
  logic                  rd_vld_q;

  // evaluation
  ent_t              ent_rd, ent_d, ent_q, ent_fin;
  logic              in_rng;
  logic              en_d, en_q;
  logic              go_d, go_q;
  logic [1:0]        sts_d, sts_q, sts_fin;
  logic              need_div;
  div_req_t          div_req;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] since_last;
  logic              used, fast, beat;
  logic [CFG_W-1:0]  intv;
  logic              div_done;
  logic [RATE_W-1:0] div_rate;

  // result register
  logic              out_vld_q;
  logic [PEER_W-1:0] out_peer_q;
  logic              out_beat_q, out_used_q, out_fast_q, out_trk_q;
  logic [RATE_W-1:0] out_rate_q;
  logic [1:0]        out_sts_q;

  logic accept;

  assign accept      = start_i && (st_q == S_IDLE);
  assign busy_o      = (st_q != S_IDLE);
  assign cfg_ready_o = (st_q == S_IDLE);

  // ---------------------------------------------------------------------------
  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q  <= '0;
      fast_q <= RST_FAST_INTV;
      slow_q <= RST_SLOW_INTV;
      win_q  <= RST_RATE_WIN;
      thr_q  <= RST_HIGH_THR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OWN_LINK:  own_q  <= cfg_data_i;
        CFG_FAST_INTV: fast_q <= cfg_data_i;
        CFG_SLOW_INTV: slow_q <= cfg_data_i;
        CFG_RATE_WIN:  win_q  <= cfg_data_i;
        CFG_HIGH_THR:  thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // evaluate: tracking, status, rebaseline and window check
  assign ent_rd  = rd_vld_q ? rd_q : '0;
  assign in_rng  = 32'(peer_q) < PEER_SLOTS;
  assign elapsed = now_q - ent_rd.window_start;

  always_comb begin
    ent_d    = ent_rd;
    en_d     = (own_q != '0) && in_rng;
    go_d     = 1'b0;
    sts_d    = STS_SKIP;
    need_div = 1'b0;
    div_req  = '0;
    if (!in_rng) ent_d = '0;
    if (en_d) begin
      if (path_q == PATH_PRESENT && !ent_rd.tracked) begin
        ent_d         = '0;
        ent_d.tracked = 1'b1;
      end else if (path_q == PATH_ABSENT && ent_rd.tracked) begin
        ent_d = '0;
      end
      if (path_q != PATH_PRESENT && path_q != PATH_ABSENT) sts_d = STS_PATH_ERR;
      else if (now_q == '0)                                 sts_d = STS_SKIP;
      else                                                  sts_d = STS_OK;
      go_d = (sts_d == STS_OK) && (path_q == PATH_PRESENT);
      if (go_d) begin
        if (!ent_d.baseline || total_q < ent_d.last_total ||
            now_q < ent_d.window_start) begin
          ent_d.window_start = now_q;
          ent_d.last_total   = total_q;
          ent_d.last_beat    = '0;
          ent_d.rate         = '0;
          ent_d.baseline     = 1'b1;
        end else if (elapsed != '0 && elapsed >= TIME_W'(win_q)) begin
          need_div           = 1'b1;
          div_req.delta      = total_q - ent_d.last_total;
          div_req.elapsed    = elapsed;
          ent_d.window_start = now_q;
          ent_d.last_total   = total_q;
        end
      end
    end
  end

  pahs_rate_div u_rate_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   ((st_q == S_EVAL) && need_div),
    .req_i  (div_req),
    .done_o (div_done),
    .rate_o (div_rate)
  );

  // ---------------------------------------------------------------------------
  // finish: plan use, interval choice and heartbeat decision
  assign since_last = now_q - ent_q.last_beat;

  always_comb begin
    ent_fin = ent_q;
    sts_fin = sts_q;
    used    = 1'b0;
    fast    = 1'b0;
    beat    = 1'b0;
    intv    = '0;
    if (go_q) begin
      if (pst_q == PLAN_VALID) begin
        if (mode_q == MODE_SINGLE)         used = (prim_q == own_q);
        else if (mode_q == MODE_REDUNDANT) used = (prim_q == own_q) || (sec_q == own_q);
      end else if (pst_q != PLAN_NONE) begin
        sts_fin = STS_PLAN_ERR;
      end
      fast = used && (ent_q.rate <= thr_q);
      intv = fast ? fast_q : slow_q;
      if (intv != '0 && (ent_q.last_beat == '0 || now_q < ent_q.last_beat ||
                         since_last >= TIME_W'(intv))) begin
        beat = 1'b1;
      end
      if (beat) ent_fin.last_beat = now_q;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (start_i) st_d = S_EVAL;
      S_EVAL: st_d = need_div ? S_DIV : S_FIN;
      S_DIV:  if (div_done) st_d = S_FIN;
      S_FIN:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      out_vld_q <= (st_q == S_FIN);
      if (st_q == S_FIN && en_q) vld_q[peer_q[PEER_AW-1:0]] <= 1'b1;
    end
  end

  // command latch and table read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      peer_q   <= peer_id_i;
      path_q   <= path_status_i;
      total_q  <= {1'b0, tx_count_i} + {1'b0, rx_count_i};
      now_q    <= now_time_us_i;
      pst_q    <= plan_status_i;
      mode_q   <= plan_mode_i;
      prim_q   <= primary_link_i;
      sec_q    <= secondary_link_i;
      rd_q     <= ent_mem[peer_id_i[PEER_AW-1:0]];
      rd_vld_q <= vld_q[peer_id_i[PEER_AW-1:0]];
    end
  end

  // working entry; write back on finish
  always_ff @(posedge clk_i) begin
    if (st_q == S_EVAL) begin
      ent_q <= ent_d;
      en_q  <= en_d;
      go_q  <= go_d;
      sts_q <= sts_d;
    end else if (st_q == S_DIV && div_done) begin
      ent_q.rate <= div_rate;
    end
    if (st_q == S_FIN) begin
      if (en_q) ent_mem[peer_q[PEER_AW-1:0]] <= ent_fin;
      out_peer_q <= peer_q;
      out_beat_q <= beat;
      out_used_q <= used;
      out_fast_q <= fast;
      out_rate_q <= ent_fin.rate;
      out_trk_q  <= ent_fin.tracked;
      out_sts_q  <= sts_fin;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_peer_id_o    = out_peer_q;
  assign send_heartbeat_o = out_beat_q;
  assign link_in_use_o    = out_used_q;
  assign fast_selected_o  = out_fast_q;
  assign peer_rate_o      = out_rate_q;
  assign peer_tracked_o   = out_trk_q;
  assign status_o         = out_sts_q;

  // ---------------------------------------------------------------------------
  // assertions
  a_strobe_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(st_q == S_FIN))
    else $error("result strobe without a finished poll");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted poll did not raise busy");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == S_DIV))
    else $error("divider finished outside the wait state");

  a_beat_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_heartbeat_o) |-> (status_o == STS_OK || status_o == STS_PLAN_ERR))
    else $error("heartbeat flagged on a skipped or failed poll");

endmodule

`default_nettype wire

// ----- hdl/pahs_rate_div.sv -----
// ----------------------------------------------------------------------------
// Packet rate divider
// Saturating (delta * 1e6) / elapsed: one multiply, one overflow check, then
// one quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module pahs_rate_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire pahs_pkg::div_req_t          req_i,
  output      logic                        done_o,
  output      logic [pahs_pkg::RATE_W-1:0] rate_o
);
  import pahs_pkg::*;

  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(RATE_W - 1);

  div_state_e          st_q, st_d;
  logic [TOT_W-1:0]    delta_q;
  logic [TIME_W-1:0]   dvs_q;
  logic [PROD_W-1:0]   prod_q;
  logic [TIME_W-1:0]   rem_q;
  logic [RATE_W-1:0]   sh_q;
  logic [RATE_W-1:0]   quo_q;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic                done_q, done_d;

  logic [PROD_W-RATE_W-1:0] prod_hi;
  logic                     sat;
  logic [TIME_W:0]          trial;
  logic [TIME_W:0]          diff;
  logic                     ge;

  assign prod_hi = prod_q[PROD_W-1:RATE_W];
  // quotient reaches 2^32 exactly when the upper product bits reach the divisor
  assign sat     = PROD_W'(prod_hi) >= PROD_W'(dvs_q);
  assign trial   = {rem_q, sh_q[RATE_W-1]};
  assign ge      = trial >= {1'b0, dvs_q};
  assign diff    = trial - {1'b0, dvs_q};

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    unique case (st_q)
      D_IDLE: begin
        if (go_i) st_d = D_MUL;
      end
      D_MUL: begin
        st_d = D_SAT;
      end
      D_SAT: begin
        cnt_d = '0;
        if (sat) begin
          st_d   = D_IDLE;
          done_d = 1'b1;
        end else begin
          st_d = D_RUN;
        end
      end
      D_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DCNT_LAST) begin
          st_d   = D_IDLE;
          done_d = 1'b1;
        end
      end
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      D_IDLE: begin
        if (go_i) begin
          delta_q <= req_i.delta;
          dvs_q   <= req_i.elapsed;
        end
      end
      D_MUL: begin
        prod_q <= PROD_W'(delta_q) * PROD_W'(RATE_SCALE);
      end
      D_SAT: begin
        if (sat) begin
          quo_q <= '1;
        end else begin
          rem_q <= TIME_W'(prod_hi);
          sh_q  <= prod_q[RATE_W-1:0];
        end
      end
      D_RUN: begin
        rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
        sh_q  <= sh_q << 1;
        quo_q <= {quo_q[RATE_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign rate_o = quo_q;

endmodule

`default_nettype wire

// ----- bench/tb_per_peer_adaptive_heartbeat_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-peer adaptive heartbeat scheduler testbench
// Sends polls through the start/busy command port and predicts each result
// with a software copy of the peer table and the five registers. Every result
// strobe is compared field by field with the oldest prediction still pending.
// Directed polls cover the disabled block, tracking, the rate window and the
// send plan. Random traffic then runs under several register settings.
// ----------------------------------------------------------------------------
module tb_per_peer_adaptive_heartbeat_scheduler;
  import pahs_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int CYCLE_CAP  = 250000;
  localparam int SETTLE_CYC = 60;
  localparam int MAX_REPORT = 10;

  localparam logic [1:0] PATH_ERR   = 2'd2;
  localparam logic [1:0] PATH_RSVD  = 2'd3;
  localparam logic [1:0] PLAN_ERR   = 2'd2;
  localparam logic [1:0] PLAN_RSVD  = 2'd3;
  localparam logic [1:0] MODE_OTHER = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [PEER_W-1:0] peer;
    logic [1:0]        path;
    logic [CNT_W-1:0]  tx;
    logic [CNT_W-1:0]  rx;
    logic [TIME_W-1:0] now;
    logic [1:0]        plan;
    logic [1:0]        mode;
    logic [LINK_W-1:0] prim;
    logic [LINK_W-1:0] sec;
  } poll_t;

  typedef struct packed {
    logic [PEER_W-1:0] peer;
    logic              beat;
    logic              used;
    logic              fast;
    logic [RATE_W-1:0] rate;
    logic              tracked;
    logic [1:0]        status;
  } verdict_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [PEER_W-1:0]   peer_id_i;
  logic [1:0]          path_status_i;
  logic [CNT_W-1:0]    tx_count_i;
  logic [CNT_W-1:0]    rx_count_i;
  logic [TIME_W-1:0]   now_time_us_i;
  logic [1:0]          plan_status_i;
  logic [1:0]          plan_mode_i;
  logic [LINK_W-1:0]   primary_link_i;
  logic [LINK_W-1:0]   secondary_link_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_index_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                out_valid_o;
  logic [PEER_W-1:0]   out_peer_id_o;
  logic                send_heartbeat_o;
  logic                link_in_use_o;
  logic                fast_selected_o;
  logic [RATE_W-1:0]   peer_rate_o;
  logic                peer_tracked_o;
  logic [1:0]          status_o;

  per_peer_adaptive_heartbeat_scheduler i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .peer_id_i        (peer_id_i),
    .path_status_i    (path_status_i),
    .tx_count_i       (tx_count_i),
    .rx_count_i       (rx_count_i),
    .now_time_us_i    (now_time_us_i),
    .plan_status_i    (plan_status_i),
    .plan_mode_i      (plan_mode_i),
    .primary_link_i   (primary_link_i),
    .secondary_link_i (secondary_link_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_peer_id_o    (out_peer_id_o),
    .send_heartbeat_o (send_heartbeat_o),
    .link_in_use_o    (link_in_use_o),
    .fast_selected_o  (fast_selected_o),
    .peer_rate_o      (peer_rate_o),
    .peer_tracked_o   (peer_tracked_o),
    .status_o         (status_o)
  );

  // Registers as the block should hold them
  logic [CFG_W-1:0] own_link, fast_intv, slow_intv, rate_win, high_thr;

  // Peer table as the block should hold it
  logic              trk_tab  [PEER_SLOTS];
  logic              base_tab [PEER_SLOTS];
  logic [TIME_W-1:0] win_tab  [PEER_SLOTS];
  logic [TOT_W-1:0]  tot_tab  [PEER_SLOTS];
  logic [TIME_W-1:0] beat_tab [PEER_SLOTS];
  logic [RATE_W-1:0] rate_tab [PEER_SLOTS];

  // Per-peer clock and counters used to build well-formed poll sequences
  logic [TIME_W-1:0] peer_time [PEER_SLOTS];
  logic [CNT_W-1:0]  peer_tx   [PEER_SLOTS];
  logic [CNT_W-1:0]  peer_rx   [PEER_SLOTS];

  verdict_t outcome_q [$];
  int       fault_cnt  = 0;
  int       cycle_cnt  = 0;
  int       burst_left = 0;
  bit       idle_on    = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void wipe_peer(int s, logic trk);
    trk_tab[s]  = trk;
    base_tab[s] = 1'b0;
    win_tab[s]  = '0;
    tot_tab[s]  = '0;
    beat_tab[s] = '0;
    rate_tab[s] = '0;
  endfunction

  function automatic void reset_table();
    own_link  = '0;
    fast_intv = RST_FAST_INTV;
    slow_intv = RST_SLOW_INTV;
    rate_win  = RST_RATE_WIN;
    high_thr  = RST_HIGH_THR;
    for (int s = 0; s < PEER_SLOTS; s++) begin
      wipe_peer(s, 1'b0);
      peer_time[s] = '0;
      peer_tx[s]   = '0;
      peer_rx[s]   = '0;
    end
  endfunction

  // Packets per second over the window, exact in 128 bits, then saturated
  function automatic logic [RATE_W-1:0] packet_rate(logic [TOT_W-1:0] delta,
                                                    logic [TIME_W-1:0] elapsed);
    logic [127:0] q;
    q = ({79'd0, delta} * {108'd0, RATE_SCALE}) / {80'd0, elapsed};
    return (q > 128'hFFFF_FFFF) ? '1 : q[RATE_W-1:0];
  endfunction

  // Apply one poll to the table and return the result it must produce
  function automatic verdict_t schedule_poll(poll_t p);
    verdict_t          v;
    logic [TOT_W-1:0]  total;
    logic [TIME_W-1:0] elapsed;
    logic [CFG_W-1:0]  intv;
    int                s;
    v       = '0;
    v.peer  = p.peer;
    s       = int'(p.peer);
    total   = {1'b0, p.tx} + {1'b0, p.rx};
    if (own_link == '0) begin
      v.rate    = rate_tab[s];
      v.tracked = trk_tab[s];
      v.status  = STS_SKIP;
      return v;
    end
    if (p.path == PATH_PRESENT && !trk_tab[s])
      wipe_peer(s, 1'b1);
    else if (p.path == PATH_ABSENT && trk_tab[s])
      wipe_peer(s, 1'b0);

    if (p.path != PATH_PRESENT && p.path != PATH_ABSENT)
      v.status = STS_PATH_ERR;
    else if (p.now == '0)
      v.status = STS_SKIP;
    else
      v.status = STS_OK;

    if (v.status == STS_OK && p.path == PATH_PRESENT) begin
      if (!base_tab[s] || total < tot_tab[s] || p.now < win_tab[s]) begin
        // restart the window from this poll
        win_tab[s]  = p.now;
        tot_tab[s]  = total;
        beat_tab[s] = '0;
        rate_tab[s] = '0;
        base_tab[s] = 1'b1;
      end else begin
        elapsed = p.now - win_tab[s];
        if (elapsed != '0 && elapsed >= TIME_W'(rate_win)) begin
          rate_tab[s] = packet_rate(total - tot_tab[s], elapsed);
          win_tab[s]  = p.now;
          tot_tab[s]  = total;
        end
      end

      if (p.plan == PLAN_VALID) begin
        if (p.mode == MODE_SINGLE)
          v.used = (p.prim == own_link);
        else if (p.mode == MODE_REDUNDANT)
          v.used = (p.prim == own_link) || (p.sec == own_link);
      end else if (p.plan != PLAN_NONE) begin
        v.status = STS_PLAN_ERR;
      end

      v.fast = v.used && (rate_tab[s] <= high_thr);
      intv   = v.fast ? fast_intv : slow_intv;
      if (intv != '0 && (beat_tab[s] == '0 || p.now < beat_tab[s] ||
                         p.now - beat_tab[s] >= TIME_W'(intv))) begin
        v.beat      = 1'b1;
        beat_tab[s] = p.now;
      end
    end
    v.rate    = rate_tab[s];
    v.tracked = trk_tab[s];
    return v;
  endfunction

  task automatic cmp_field(string name, logic [7:0] peer, logic [63:0] want,
                           logic [63:0] got);
    if (want !== got) begin
      fault_cnt++;
      if (fault_cnt <= MAX_REPORT)
        $display("mismatch on %s, peer %0d: expected %0h, got %0h", name, peer, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && out_valid_o) begin
      if (outcome_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= MAX_REPORT)
          $display("result for peer %0d with no poll pending", out_peer_id_o);
      end else begin
        want = outcome_q.pop_front();
        cmp_field("out_peer_id", want.peer, 64'(want.peer), 64'(out_peer_id_o));
        cmp_field("send_heartbeat", want.peer, 64'(want.beat), 64'(send_heartbeat_o));
        cmp_field("link_in_use", want.peer, 64'(want.used), 64'(link_in_use_o));
        cmp_field("fast_selected", want.peer, 64'(want.fast), 64'(fast_selected_o));
        cmp_field("peer_rate", want.peer, 64'(want.rate), 64'(peer_rate_o));
        cmp_field("peer_tracked", want.peer, 64'(want.tracked), 64'(peer_tracked_o));
        cmp_field("status", want.peer, 64'(want.status), 64'(status_o));
      end
    end
  end

  // One poll beat; start stays high across a burst and drops only for a gap
  task automatic send_poll(poll_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (idle_on && gap != 0) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    start_i          <= 1'b1;
    peer_id_i        <= p.peer;
    path_status_i    <= p.path;
    tx_count_i       <= p.tx;
    rx_count_i       <= p.rx;
    now_time_us_i    <= p.now;
    plan_status_i    <= p.plan;
    plan_mode_i      <= p.mode;
    primary_link_i   <= p.prim;
    secondary_link_i <= p.sec;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    outcome_q.push_back(schedule_poll(p));
  endtask

  // Hold off until every result is back and the block has gone quiet
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_OWN_LINK:  own_link  = val;
      CFG_FAST_INTV: fast_intv = val;
      CFG_SLOW_INTV: slow_intv = val;
      CFG_RATE_WIN:  rate_win  = val;
      CFG_HIGH_THR:  high_thr  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_config(logic [CFG_W-1:0] own, logic [CFG_W-1:0] fast,
                              logic [CFG_W-1:0] slow, logic [CFG_W-1:0] win,
                              logic [CFG_W-1:0] thr);
    drain();
    write_reg(CFG_OWN_LINK, own);
    write_reg(CFG_FAST_INTV, fast);
    write_reg(CFG_SLOW_INTV, slow);
    write_reg(CFG_RATE_WIN, win);
    write_reg(CFG_HIGH_THR, thr);
  endtask

  function automatic poll_t mk_poll(logic [PEER_W-1:0] peer, logic [1:0] path,
                                    logic [CNT_W-1:0] tx, logic [CNT_W-1:0] rx,
                                    logic [TIME_W-1:0] now, logic [1:0] plan,
                                    logic [1:0] mode, logic [LINK_W-1:0] prim,
                                    logic [LINK_W-1:0] sec);
    poll_t p;
    p.peer = peer;
    p.path = path;
    p.tx   = tx;
    p.rx   = rx;
    p.now  = now;
    p.plan = plan;
    p.mode = mode;
    p.prim = prim;
    p.sec  = sec;
    return p;
  endfunction

  function automatic logic [CNT_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CNT_W-1:0];
  endfunction

  // Next poll in a peer's sequence: time and counters only move forward
  function automatic poll_t next_poll(logic [PEER_W-1:0] id, int unsigned step_hi,
                                      int unsigned dmax);
    poll_t p;
    p.peer = id;
    p.path = PATH_PRESENT;
    peer_time[id] = peer_time[id] + TIME_W'($urandom_range(0, step_hi));
    if ($urandom_range(0, 15) == 0)
      peer_tx[id] = peer_tx[id] + CNT_W'({$urandom_range(0, 15), $urandom});
    else
      peer_tx[id] = peer_tx[id] + CNT_W'($urandom_range(0, dmax));
    peer_rx[id] = peer_rx[id] + CNT_W'($urandom_range(0, dmax));
    p.now  = peer_time[id];
    p.tx   = peer_tx[id];
    p.rx   = peer_rx[id];
    p.plan = ($urandom_range(0, 9) != 0) ? PLAN_VALID : 2'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0)
      p.mode = 2'($urandom_range(0, 3));
    else
      p.mode = $urandom_range(0, 1) ? MODE_REDUNDANT : MODE_SINGLE;
    p.prim = ($urandom_range(0, 2) == 0) ? $urandom : own_link;
    p.sec  = $urandom_range(0, 1) ? $urandom : own_link;
    return p;
  endfunction

  task automatic run_traffic(int n, int unsigned step_hi, int unsigned dmax);
    logic [PEER_W-1:0] pool [6];
    poll_t             p;
    int                roll;
    for (int k = 0; k < 6; k++) begin
      pool[k] = PEER_W'($urandom_range(0, 255));
    end
    pool[0] = '0;
    pool[1] = '1;
    for (int k = 0; k < 6; k++) begin
      if (peer_time[pool[k]] == '0)
        peer_time[pool[k]] = TIME_W'($urandom_range(1, 1 << 20));
    end
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      p    = next_poll(pool[$urandom_range(0, 5)], step_hi, dmax);
      if (roll < 78) begin
        // well-formed poll as built
      end else if (roll < 82) begin
        p.path = PATH_ABSENT;
      end else if (roll < 85) begin
        p.path = $urandom_range(0, 1) ? PATH_RSVD : PATH_ERR;
      end else if (roll < 88) begin
        p.now = '0;
      end else if (roll < 91) begin
        // step the clock back
        p.now = p.now >> $urandom_range(1, 8);
        if (p.now == '0)
          p.now = TIME_W'(1);
        peer_time[p.peer] = p.now;
      end else if (roll < 94) begin
        p.tx = p.tx >> 1;
        peer_tx[p.peer] = p.tx;
      end else begin
        p = mk_poll(PEER_W'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), rand48(),
                    rand48(), rand48(), 2'($urandom_range(0, 3)),
                    2'($urandom_range(0, 3)), $urandom, $urandom);
      end
      send_poll(p);
    end
  endtask

  task automatic test_disabled_block();
    send_poll(mk_poll(8'd0, PATH_PRESENT, '0, '0, 48'd500, PLAN_VALID, MODE_SINGLE,
                      '0, '0));
    send_poll(mk_poll('1, PATH_PRESENT, CNT_MAX, CNT_MAX, '1, PLAN_VALID,
                      MODE_REDUNDANT, '1, '1));
  endtask

  task automatic test_tracking();
    apply_config(32'h0000_00A5, RST_FAST_INTV, RST_SLOW_INTV, RST_RATE_WIN, RST_HIGH_THR);
    send_poll(mk_poll(8'd1, PATH_PRESENT, 48'd3, 48'd4, '0, PLAN_VALID, MODE_SINGLE,
                      own_link, '0));
    send_poll(mk_poll(8'd1, PATH_PRESENT, 48'd10, 48'd5, 48'd1000, PLAN_VALID,
                      MODE_SINGLE, own_link, '0));
    send_poll(mk_poll(8'd1, PATH_ERR, 48'd11, 48'd5, 48'd2000, PLAN_VALID, MODE_SINGLE,
                      own_link, '0));
    send_poll(mk_poll(8'd1, PATH_RSVD, 48'd12, 48'd5, 48'd3000, PLAN_VALID,
                      MODE_SINGLE, own_link, '0));
    send_poll(mk_poll(8'd1, PATH_ABSENT, 48'd13, 48'd5, 48'd4000, PLAN_VALID,
                      MODE_SINGLE, own_link, '0));
  endtask

  task automatic test_rate_window();
    send_poll(mk_poll(8'd2, PATH_PRESENT, '0, '0, 48'd1, PLAN_VALID, MODE_SINGLE,
                      own_link, '0));
    // no time has passed: the rate stays put
    send_poll(mk_poll(8'd2, PATH_PRESENT, 48'd1, '0, 48'd1, PLAN_VALID, MODE_SINGLE,
                      own_link, '0));
    send_poll(mk_poll(8'd2, PATH_PRESENT, 48'd50, 48'd50, 48'd1000001, PLAN_VALID,
                      MODE_SINGLE, own_link, '0));
    send_poll(mk_poll(8'd2, PATH_PRESENT, 48'd151, 48'd50, 48'd2000001, PLAN_VALID,
                      MODE_SINGLE, own_link, '0));
    send_poll(mk_poll(8'd2, PATH_PRESENT, CNT_MAX, CNT_MAX, 48'd3000001, PLAN_VALID,
                      MODE_SINGLE, own_link, '0));
    send_poll(mk_poll(8'd2, PATH_PRESENT, '0, '0, 48'd4000001, PLAN_VALID, MODE_SINGLE,
                      own_link, '0));
    send_poll(mk_poll(8'd2, PATH_PRESENT, '0, '0, 48'd5, PLAN_VALID, MODE_SINGLE,
                      own_link, '0));
  endtask

  task automatic test_send_plan();
    send_poll(mk_poll(8'd3, PATH_PRESENT, 48'd1, 48'd1, 48'd50000, PLAN_NONE,
                      MODE_SINGLE, own_link, own_link));
    send_poll(mk_poll(8'd3, PATH_PRESENT, 48'd2, 48'd1, 48'd100000, PLAN_VALID,
                      MODE_REDUNDANT, '0, own_link));
    send_poll(mk_poll(8'd3, PATH_PRESENT, 48'd3, 48'd1, 48'd250000, PLAN_VALID,
                      MODE_OTHER, own_link, own_link));
    send_poll(mk_poll(8'd3, PATH_PRESENT, 48'd4, 48'd1, 48'd400000, PLAN_VALID,
                      MODE_RSVD, own_link, own_link));
    send_poll(mk_poll(8'd3, PATH_PRESENT, 48'd5, 48'd1, 48'd550000, PLAN_ERR,
                      MODE_SINGLE, own_link, '0));
    send_poll(mk_poll(8'd3, PATH_PRESENT, 48'd6, 48'd1, 48'd700000, PLAN_RSVD,
                      MODE_SINGLE, own_link, '0));
  endtask

  task automatic test_default_traffic();
    idle_on = 1'b1;
    run_traffic(150, 200000, 20);
  endtask

  task automatic test_short_windows();
    apply_config(32'h1234_5678, 32'd3000, 32'd20000, 32'd1000, 32'd5000);
    idle_on = 1'b0;
    run_traffic(60, 2000, 10);
    idle_on = 1'b1;
    run_traffic(60, 2000, 10);
  endtask

  task automatic test_config_maxima();
    apply_config('1, '0, '1, '1, '1);
    run_traffic(80, 32'hFFFF_FFFF, 1000);
  endtask

  task automatic test_config_minima();
    apply_config(32'd1, 32'd1, '0, 32'd1, '0);
    run_traffic(80, 8, 3);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    start_i          <= 1'b0;
    peer_id_i        <= '0;
    path_status_i    <= '0;
    tx_count_i       <= '0;
    rx_count_i       <= '0;
    now_time_us_i    <= '0;
    plan_status_i    <= '0;
    plan_mode_i      <= '0;
    primary_link_i   <= '0;
    secondary_link_i <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    reset_table();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_disabled_block();
    test_tracking();
    test_rate_window();
    test_send_plan();
    test_default_traffic();
    test_short_windows();
    test_config_maxima();
    test_config_minima();
    drain();

    if (fault_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
